FILE: rtl/dsft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsft_pkg
// Shared types, codes and helpers of the detector status frame tracker.
// ----------------------------------------------------------------------------
package dsft_pkg;

   // Number of tracked detectors (1 to 256)
   localparam int NUM_DETECTORS = 64;
   localparam int ADDR_W = (NUM_DETECTORS > 1) ? $clog2(NUM_DETECTORS) : 1;
   localparam logic [8:0] NUM_DET_EXT = 9'(NUM_DETECTORS);

   // Status slots per packed byte
   localparam logic [2:0] NUM_SLOTS = 3'd4;

   localparam logic [7:0] COUNT_MAX = 8'hFF;

   // Opcodes
   localparam logic [1:0] OP_FRAME  = 2'd0;
   localparam logic [1:0] OP_STATUS = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   // Detector states
   localparam logic [1:0] ST_EMPTY  = 2'd0;
   localparam logic [1:0] ST_BUSY   = 2'd1;
   localparam logic [1:0] ST_BROKEN = 2'd2;

   // Status codes inside a packed byte
   localparam logic [1:0] CODE_BUSY   = 2'd1;
   localparam logic [1:0] CODE_BROKEN = 2'd2;

   typedef logic [ADDR_W-1:0] addr_type;

   typedef struct packed {
      logic [1:0] state;
      logic [7:0] count;
   } word_type;

   typedef struct packed {
      logic     rd_en;
      addr_type rd_addr;
      logic     wr_en;
      addr_type wr_addr;
      word_type wr_data;
   } mem_req_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] state;
      logic [7:0] count;
   } result_type;

   // Map a 2-bit status code to a detector state
   function automatic logic [1:0] decode_code(input logic [1:0] code);
      logic [1:0] st;
      case (code)
         CODE_BUSY:   st = ST_BUSY;
         CODE_BROKEN: st = ST_BROKEN;
         default:     st = ST_EMPTY;
      endcase
      return st;
   endfunction

endpackage

FILE: rtl/dsft_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsft_req_if
// Request channel: opcode and value with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface dsft_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink (input valid, input opcode, input value, output ready);
endinterface

FILE: rtl/dsft_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsft_rsp_if
// Response channel: detector state and demand count with valid/ready.
// ----------------------------------------------------------------------------
interface dsft_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] detector_state;
   logic [7:0] demand_count;

   modport source (output valid, output detector_state, output demand_count, input ready);
   modport sink (input valid, input detector_state, input demand_count, output ready);
endinterface

FILE: rtl/detector_status_frame_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detector_status_frame_tracker
// Tracks detector states and demand counts from byte-wise status frames.
// ----------------------------------------------------------------------------
// Read: the table read goes out after the request is accepted, and the result
// is loaded into the output register from the registered read data; an
// out-of-range index skips the table read. The result waits while the output
// register is full. Clear and status byte run one table read-modify-write per
// slot over the single memory port pair, reads overlapped with the previous
// slot's write; a new transaction is taken only after the last one is done.
// Reset: synchronous; table valid bits clear at once, so all detectors read
// empty with count zero; base and byte offset return to zero.
// ----------------------------------------------------------------------------
module detector_status_frame_tracker (
   input logic       clock,
   input logic       reset,
   dsft_req_if.sink  req,
   dsft_rsp_if.source rsp
);
   import dsft_pkg::*;

   mem_req_type mem_req;
   word_type    rd_word;
   result_type  result;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_state_ff;
   logic [7:0] rsp_count_ff;
   logic       out_free;

   dsft_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .out_free (out_free),
      .rd_word  (rd_word),
      .mem_req  (mem_req),
      .result   (result)
   );

   dsft_store u_store (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_word (rd_word)
   );

   // Output register: free when empty or draining this cycle
   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load result payload
   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_state_ff <= result.state;
         rsp_count_ff <= result.count;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.detector_state = rsp_state_ff;
   assign rsp.demand_count   = rsp_count_ff;

   // Read and write never hit the same entry in one cycle
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (mem_req.rd_en && mem_req.wr_en) |-> (mem_req.rd_addr != mem_req.wr_addr))
      else $error("table read and write collide");

   // A new result never overwrites a result that is still waiting
   a_no_result_overrun: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> (!rsp_valid_ff || rsp.ready))
      else $error("result overruns output register");

   // No table write while a new transaction is taken
   a_accept_quiet: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |-> !mem_req.wr_en)
      else $error("write pending at transaction accept");

   // A delivered state is a legal detector state
   a_state_legal: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.detector_state != 2'd3))
      else $error("illegal detector state delivered");

endmodule

FILE: rtl/dsft_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsft_store
// Detector table: one word per detector (state and demand count) in a
// synchronous memory with registered read data, plus per-entry valid bits
// so that an entry never written since reset reads as empty with count zero.
// ----------------------------------------------------------------------------
module dsft_store (
   input  logic                 clock,
   input  logic                 reset,
   input  dsft_pkg::mem_req_type mem_req,
   output dsft_pkg::word_type    rd_word
);
   import dsft_pkg::*;

   word_type                 mem_ff [NUM_DETECTORS];
   logic [NUM_DETECTORS-1:0] valid_ff;
   word_type                 rd_data_ff;
   logic                     rd_hit_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // Read port, registered; hold data between reads
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   // Track written entries
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         if (mem_req.wr_en) begin
            valid_ff[mem_req.wr_addr] <= 1'b1;
         end
         if (mem_req.rd_en) begin
            rd_hit_ff <= valid_ff[mem_req.rd_addr];
         end
      end
   end

   // Unwritten entry reads as the reset value
   assign rd_word = rd_hit_ff ? rd_data_ff : '0;

endmodule

FILE: rtl/dsft_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsft_ctrl
// Sequencer: takes one transaction, walks its detector slots through
// read-modify-write of the table, and produces the read result.
// ----------------------------------------------------------------------------
module dsft_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   dsft_req_if.sink              req,
   input  logic                  out_free,
   input  dsft_pkg::word_type    rd_word,
   output dsft_pkg::mem_req_type mem_req,
   output dsft_pkg::result_type  result
);
   import dsft_pkg::*;

   localparam logic FSM_IDLE = 1'b0;
   localparam logic FSM_RUN  = 1'b1;

   logic       fsm_ff, fsm_in;
   logic [1:0] op_ff, op_in;
   logic [7:0] base_ff, base_in;
   logic [7:0] code_ff, code_in;
   logic [2:0] slot_ff, slot_in;
   logic       pend_ff, pend_in;
   addr_type   pend_addr_ff, pend_addr_in;
   logic [1:0] pend_code_ff, pend_code_in;
   logic [7:0] frame_base_ff, frame_base_in;
   logic [5:0] byte_offset_ff, byte_offset_in;

   logic       accept;
   logic       running;
   logic [7:0] cur_idx;
   logic [2:0] slot_lim;
   logic       in_range;
   logic       issue;
   logic       res_avail;
   logic       stall;
   logic [1:0] slot_code;
   logic [7:0] next_count;

   assign req.ready = (fsm_ff == FSM_IDLE);
   assign accept    = req.valid && req.ready;
   assign running   = (fsm_ff == FSM_RUN);

   // Current detector index and whether another slot goes out
   assign cur_idx   = base_ff + 8'(slot_ff[1:0]);
   assign slot_lim  = (op_ff == OP_STATUS) ? NUM_SLOTS : 3'd1;
   assign in_range  = ({1'b0, cur_idx} < NUM_DET_EXT);
   assign issue     = running && (slot_ff < slot_lim) && in_range;
   assign slot_code = decode_code(code_ff[{slot_ff[1:0], 1'b0} +: 2]);

   // Read result is ready with the table data, or at once when out of range
   assign res_avail = running && (op_ff == OP_READ) &&
                      (pend_ff || ((slot_ff == 3'd0) && !issue));
   assign stall     = res_avail && !out_free;

   assign result.valid = res_avail && out_free;
   assign result.state = pend_ff ? rd_word.state : ST_BROKEN;
   assign result.count = pend_ff ? rd_word.count : 8'd0;

   // Saturating count on an empty-to-busy change
   always_comb begin
      next_count = rd_word.count;
      if ((rd_word.state == ST_EMPTY) && (pend_code_ff == ST_BUSY) &&
          (rd_word.count != COUNT_MAX)) begin
         next_count = rd_word.count + 8'd1;
      end
   end

   // Table access
   always_comb begin
      mem_req.rd_en   = issue && !stall;
      mem_req.rd_addr = cur_idx[ADDR_W-1:0];
      mem_req.wr_en   = running && pend_ff && (op_ff != OP_READ);
      mem_req.wr_addr = pend_addr_ff;
      if (op_ff == OP_STATUS) begin
         mem_req.wr_data.state = pend_code_ff;
         mem_req.wr_data.count = next_count;
      end else begin
         mem_req.wr_data.state = rd_word.state;
         mem_req.wr_data.count = 8'd0;
      end
   end

   // Next state
   always_comb begin
      fsm_in         = fsm_ff;
      op_in          = op_ff;
      base_in        = base_ff;
      code_in        = code_ff;
      slot_in        = slot_ff;
      pend_in        = pend_ff;
      pend_addr_in   = pend_addr_ff;
      pend_code_in   = pend_code_ff;
      frame_base_in  = frame_base_ff;
      byte_offset_in = byte_offset_ff;
      if (accept) begin
         op_in   = req.opcode;
         code_in = req.value;
         slot_in = 3'd0;
         pend_in = 1'b0;
         case (req.opcode)
            OP_FRAME: begin
               frame_base_in  = req.value;
               byte_offset_in = 6'd0;
            end
            OP_STATUS: begin
               base_in        = frame_base_ff + {byte_offset_ff, 2'b00};
               byte_offset_in = byte_offset_ff + 6'd1;
               fsm_in         = FSM_RUN;
            end
            default: begin
               base_in = req.value;
               fsm_in  = FSM_RUN;
            end
         endcase
      end else if (running && !stall) begin
         pend_in = issue;
         if (issue) begin
            slot_in      = slot_ff + 3'd1;
            pend_addr_in = cur_idx[ADDR_W-1:0];
            pend_code_in = slot_code;
         end else begin
            fsm_in = FSM_IDLE;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff         <= FSM_IDLE;
         pend_ff        <= 1'b0;
         slot_ff        <= 3'd0;
         frame_base_ff  <= 8'd0;
         byte_offset_ff <= 6'd0;
      end else begin
         fsm_ff         <= fsm_in;
         pend_ff        <= pend_in;
         slot_ff        <= slot_in;
         frame_base_ff  <= frame_base_in;
         byte_offset_ff <= byte_offset_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      base_ff      <= base_in;
      code_ff      <= code_in;
      pend_addr_ff <= pend_addr_in;
      pend_code_ff <= pend_code_in;
   end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the detector status frame tracker. A queue-fed
// driver sends frame starts, status bytes, reads and clears. A shadow model
// of the state and count tables predicts every read. A monitor checks each
// response field by field, under three receive/send idle mixes.
// ----------------------------------------------------------------------------
module testbench;
   import dsft_pkg::*;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] value;
   } tracker_req_type;

   typedef struct packed {
      logic [1:0] state;
      logic [7:0] count;
   } detector_read_type;

   logic clock;
   logic reset;

   dsft_req_if req_ch ();
   dsft_rsp_if rsp_ch ();

   detector_status_frame_tracker dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Shadow copy of the tracker state
   logic [1:0] state_model [NUM_DETECTORS];
   logic [7:0] count_model [NUM_DETECTORS];
   logic [7:0] base_model;
   logic [5:0] offset_model;

   tracker_req_type   req_backlog[$];
   detector_read_type reads_due[$];
   tracker_req_type   next_req;
   detector_read_type seen_read;

   int  send_idle_pct;
   int  recv_idle_pct;
   int  queued_count;
   int  accepted_count;
   int  error_count;
   bit  req_taken;

   // Free-running clock
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Run limit
   initial begin
      #4_000_000;
      $display("FAIL detector_status_frame_tracker");
      $finish;
   end

   // Advance the shadow model by one accepted transaction
   task automatic model_transaction(input logic [1:0] op, input logic [7:0] val);
      logic [7:0]        idx;
      logic [1:0]        code;
      logic [1:0]        next_st;
      bit                stopped;
      detector_read_type rd;
      stopped = 1'b0;
      case (op)
         OP_FRAME: begin
            base_model   = val;
            offset_model = '0;
         end
         OP_STATUS: begin
            for (int slot = 0; slot < 4; slot++) begin
               idx = base_model + {offset_model, 2'b00} + 8'(slot);
               // stop at the first slot past the detector count
               if (!stopped && int'(idx) >= NUM_DETECTORS) stopped = 1'b1;
               if (!stopped) begin
                  code = val[2*slot +: 2];
                  if (code == CODE_BUSY) next_st = ST_BUSY;
                  else if (code == CODE_BROKEN) next_st = ST_BROKEN;
                  else next_st = ST_EMPTY;
                  if (state_model[idx[ADDR_W-1:0]] == ST_EMPTY && next_st == ST_BUSY &&
                      count_model[idx[ADDR_W-1:0]] != COUNT_MAX)
                     count_model[idx[ADDR_W-1:0]] = count_model[idx[ADDR_W-1:0]] + 8'd1;
                  state_model[idx[ADDR_W-1:0]] = next_st;
               end
            end
            offset_model = offset_model + 6'd1;
         end
         OP_READ: begin
            if (int'(val) < NUM_DETECTORS) begin
               rd.state = state_model[val[ADDR_W-1:0]];
               rd.count = count_model[val[ADDR_W-1:0]];
            end else begin
               rd.state = ST_BROKEN;
               rd.count = 8'd0;
            end
            reads_due.push_back(rd);
         end
         default: begin
            if (int'(val) < NUM_DETECTORS) count_model[val[ADDR_W-1:0]] = 8'd0;
         end
      endcase
   endtask

   task automatic queue_item(input logic [1:0] op, input logic [7:0] val);
      tracker_req_type it;
      it.opcode = op;
      it.value  = val;
      req_backlog.push_back(it);
      queued_count++;
   endtask

   // Hold off until every transaction is taken and every read has returned
   task automatic drain();
      while (accepted_count != queued_count || reads_due.size() != 0)
         @(negedge clock);
   endtask

   // Mostly an in-range detector, now and then any index
   function automatic logic [7:0] pick_detector();
      if ($urandom_range(7) == 0) return 8'($urandom_range(255));
      return 8'($urandom_range(NUM_DETECTORS - 1));
   endfunction

   // Mostly well-formed frames with random content, the rest noise
   task automatic queue_random_traffic(input int amount);
      int         added;
      int         pick;
      int         len;
      logic [7:0] val;
      added = 0;
      while (added < amount) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            pick = $urandom_range(9);
            if (pick < 6) val = 8'($urandom_range(NUM_DETECTORS - 1));
            else if (pick < 8) val = 8'(256 - $urandom_range(1, 8));
            else val = 8'($urandom_range(255));
            queue_item(OP_FRAME, val);
            added++;
            len = $urandom_range(1, 18);
            for (int k = 0; k < len; k++) begin
               queue_item(OP_STATUS, 8'($urandom_range(255)));
               added++;
               if ($urandom_range(3) == 0) begin
                  queue_item(OP_READ, pick_detector());
                  added++;
               end
               if ($urandom_range(19) == 0) begin
                  val = pick_detector();
                  queue_item(OP_CLEAR, val);
                  if (int'(val) < NUM_DETECTORS) added++;
               end
            end
         end else if (pick < 85) begin
            queue_item(OP_READ, pick_detector());
            added++;
         end else if (pick < 92) begin
            val = pick_detector();
            queue_item(OP_CLEAR, val);
            if (int'(val) < NUM_DETECTORS) added++;
         end else begin
            queue_item(2'($urandom_range(3)), 8'($urandom_range(255)));
            added++;
         end
      end
   endtask

   // Driver: present the next pending transaction at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_req = req_backlog.pop_front();
            req_ch.valid  <= 1'b1;
            req_ch.opcode <= next_req.opcode;
            req_ch.value  <= next_req.value;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver: stall responses at random
   always @(negedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Monitor: check responses, then feed accepted requests to the model
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (reset) begin
         for (int i = 0; i < NUM_DETECTORS; i++) begin
            state_model[i] = ST_EMPTY;
            count_model[i] = 8'd0;
         end
         base_model   = 8'd0;
         offset_model = 6'd0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (reads_due.size() == 0) begin
               $error("response with no read pending: state %0d, count %0d",
                      rsp_ch.detector_state, rsp_ch.demand_count);
               error_count++;
            end else begin
               seen_read = reads_due.pop_front();
               if (rsp_ch.detector_state !== seen_read.state) begin
                  $error("detector_state mismatch: expected %0d, actual %0d",
                         seen_read.state, rsp_ch.detector_state);
                  error_count++;
               end
               if (rsp_ch.demand_count !== seen_read.count) begin
                  $error("demand_count mismatch: expected %0d, actual %0d",
                         seen_read.count, rsp_ch.demand_count);
                  error_count++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            req_taken = 1'b1;
            accepted_count++;
            model_transaction(req_ch.opcode, req_ch.value);
         end
      end
   end

   // Stimulus sequence
   initial begin
      reset          = 1'b1;
      send_idle_pct  = 26;
      recv_idle_pct  = 72;

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Directed: reset contents, edge indexes, wrap and stop cases
      queue_item(OP_READ, 8'd0);
      queue_item(OP_READ, 8'(NUM_DETECTORS - 1));
      queue_item(OP_READ, 8'(NUM_DETECTORS));
      queue_item(OP_READ, 8'd255);
      queue_item(OP_STATUS, 8'h55);     // no frame start yet: base zero
      queue_item(OP_STATUS, 8'hAA);
      queue_item(OP_STATUS, 8'hFF);     // code 3 reads as empty
      queue_item(OP_FRAME, 8'(NUM_DETECTORS - 2));
      queue_item(OP_STATUS, 8'h55);     // last two in range, then stop
      queue_item(OP_FRAME, 8'd254);
      queue_item(OP_STATUS, 8'h55);     // stop at once, no wrap to 0 and 1
      queue_item(OP_STATUS, 8'h66);     // next byte wraps into range
      queue_item(OP_FRAME, 8'd10);
      queue_item(OP_FRAME, 8'd0);       // frame start with no status bytes
      queue_item(OP_STATUS, 8'h01);     // busy to busy: no count
      queue_item(OP_FRAME, 8'd4);
      queue_item(OP_STATUS, 8'h01);     // broken to busy: no count
      queue_item(OP_READ, 8'd0);
      queue_item(OP_READ, 8'd1);
      queue_item(OP_READ, 8'd4);
      queue_item(OP_READ, 8'(NUM_DETECTORS - 2));
      queue_item(OP_CLEAR, 8'd0);
      queue_item(OP_CLEAR, 8'd200);     // out of range: ignored
      queue_item(OP_READ, 8'd0);
      queue_item(OP_READ, 8'(NUM_DETECTORS - 1));
      drain();

      // Slow receiver
      queue_random_traffic(40);
      drain();

      // Slow sender
      send_idle_pct = 72;
      recv_idle_pct = 26;
      queue_random_traffic(40);
      drain();

      // No idling: drive the top four counts into saturation
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int n = 0; n < 256; n++) begin
         queue_item(OP_FRAME, 8'(NUM_DETECTORS - 4));
         queue_item(OP_STATUS, 8'h55);
         queue_item(OP_FRAME, 8'(NUM_DETECTORS - 4));
         queue_item(OP_STATUS, 8'h00);
      end
      queue_item(OP_FRAME, 8'(NUM_DETECTORS - 4));
      queue_item(OP_STATUS, 8'h55);
      for (int d = NUM_DETECTORS - 4; d < NUM_DETECTORS; d++) queue_item(OP_READ, 8'(d));
      queue_item(OP_CLEAR, 8'(NUM_DETECTORS - 3));
      queue_item(OP_READ, 8'(NUM_DETECTORS - 3));
      queue_random_traffic(15);
      drain();

      // Let the pipeline settle before the verdict
      repeat (20) @(negedge clock);
      if (error_count == 0) begin
         $display("PASS detector_status_frame_tracker");
      end else begin
         $display("FAIL detector_status_frame_tracker");
      end
      $finish;
   end

endmodule
